// ===== rtl/core/block_fit_allocator_assert.svh =====
// assertion macros shared by the block fit allocator rtl
`ifndef BLOCK_FIT_ALLOCATOR_ASSERT_SVH
`define BLOCK_FIT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, idle while reset is applied
`define BFA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("block fit allocator assertion failed");
// checked property, also during reset
`define BFA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("block fit allocator assertion failed");
`else
`define BFA_ASSERT(name, prop)
`define BFA_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/core/bfa_pkg.sv =====
// shared constants, codes and types of the block fit allocator
package bfa_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int SIZE_BITS  = 16;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int POL_W      = 2;
  localparam int STAT_W     = 2;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // fit policies, code three behaves as first fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_LOADED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_GRANTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_WRITE,
    S_EMIT
  } state_e;

  // access to the block table
  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
  } tbl_req_t;

  // operands of the shared fit comparator
  typedef struct packed {
    logic [POL_W-1:0]     policy;
    logic [SIZE_BITS-1:0] request;
    logic [SIZE_BITS-1:0] avail;
    logic                 have_pick;
    logic [SIZE_BITS-1:0] pick_avail;
  } cmp_in_t;

endpackage

// ===== rtl/core/block_fit_allocator.sv =====
// block fit allocator top level: sequencer, configuration, output register
// usage
//   input channel (in_valid_i / in_stall_o): one request carries op_i,
//   block_index_i and size_i. a load writes a block's free size and clears
//   the halted flag; an allocate searches blocks 0 .. block_count-1 under
//   fit_policy and takes size_i from the chosen block
//   output channel (out_valid_o / out_stall_i): exactly one result per
//   request, status_o, chosen_block_o and remaining_o
//   configuration channel (cfg_valid_i / cfg_ready_o): always ready, index 0
//   is fit_policy and index 1 is block_count; write only while idle
// timing: one request at a time, set by the table scan, which reads one block
//   per cycle through the single read port into the shared comparator. a load or
//   refusal skips the scan; an allocate searches n = block_count capped at 64
//   blocks, none when n is zero, and a grant adds a write of the picked block.
//   the result enters the output register as the sequencer returns to idle,
//   where the next request is taken
// reset: table reads as all zero, halted cleared, first fit, 64 blocks searched
// stall: a result holds in the output register while out_stall_i is high; the
//   next request is still taken and worked on, and waits only to hand over its
//   result
module block_fit_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [bfa_pkg::IDX_W-1:0]      block_index_i,
  input  logic [bfa_pkg::SIZE_BITS-1:0]  size_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bfa_pkg::STAT_W-1:0]     status_o,
  output logic [bfa_pkg::IDX_W-1:0]      chosen_block_o,
  output logic [bfa_pkg::SIZE_BITS-1:0]  remaining_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  `include "block_fit_allocator_assert.svh"

  // sequencer state
  bfa_pkg::state_e state_q, state_d;

  // configuration
  logic [bfa_pkg::POL_W-1:0]      fit_policy_q;
  logic [bfa_pkg::CFG_DATA_W-1:0] block_count_q;

  // latched request
  logic                          op_q, op_d;
  logic [bfa_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [bfa_pkg::SIZE_BITS-1:0] size_q, size_d;

  // scan control
  logic [bfa_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [bfa_pkg::CNT_W-1:0]     limit_q, limit_d;
  logic                          pv_q, pv_d;
  logic [bfa_pkg::ADDR_W-1:0]    ptag_q, ptag_d;
  logic                          have_pick_q, have_pick_d;
  logic [bfa_pkg::ADDR_W-1:0]    pick_q, pick_d;
  logic [bfa_pkg::SIZE_BITS-1:0] best_q, best_d;

  logic halted_q, halted_d;

  // pending result and output register
  logic [bfa_pkg::STAT_W-1:0]    res_status_q, res_status_d;
  logic [bfa_pkg::IDX_W-1:0]     res_chosen_q, res_chosen_d;
  logic [bfa_pkg::SIZE_BITS-1:0] res_remaining_q, res_remaining_d;
  logic                          out_valid_q, out_valid_d;
  logic [bfa_pkg::STAT_W-1:0]    out_status_q, out_status_d;
  logic [bfa_pkg::IDX_W-1:0]     out_chosen_q, out_chosen_d;
  logic [bfa_pkg::SIZE_BITS-1:0] out_remaining_q, out_remaining_d;

  // table and comparator
  bfa_pkg::tbl_req_t             tbl_req;
  logic [bfa_pkg::SIZE_BITS-1:0] tbl_rdata;
  bfa_pkg::cmp_in_t              cmp_in;
  logic                          take;

  logic                      idx_ok;
  logic [bfa_pkg::CNT_W-1:0] count_sat;
  logic                      rd_more;

  bfa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rdata)
  );

  bfa_cmp u_cmp (
    .cmp_i  (cmp_in),
    .take_o (take)
  );

  // comparator sees the block that came back from the table this cycle
  assign cmp_in.policy     = fit_policy_q;
  assign cmp_in.request    = size_q;
  assign cmp_in.avail      = tbl_rdata;
  assign cmp_in.have_pick  = have_pick_q;
  assign cmp_in.pick_avail = best_q;

  // load beyond the table drops the write
  assign idx_ok = (bfa_pkg::CNT_W'(idx_q) < bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS));

  // searched count saturates at the table depth
  assign count_sat = (bfa_pkg::CNT_W'(block_count_q) > bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS))
                   ? bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS)
                   : bfa_pkg::CNT_W'(block_count_q);

  assign rd_more = (cnt_q < limit_q);

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    idx_d           = idx_q;
    size_d          = size_q;
    cnt_d           = cnt_q;
    limit_d         = limit_q;
    pv_d            = 1'b0;
    ptag_d          = ptag_q;
    have_pick_d     = have_pick_q;
    pick_d          = pick_q;
    best_d          = best_q;
    halted_d        = halted_q;
    res_status_d    = res_status_q;
    res_chosen_d    = res_chosen_q;
    res_remaining_d = res_remaining_q;
    out_valid_d     = out_valid_q;
    out_status_d    = out_status_q;
    out_chosen_d    = out_chosen_q;
    out_remaining_d = out_remaining_q;
    tbl_req         = '0;

    // result taken by the receiver
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bfa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          idx_d   = block_index_i;
          size_d  = size_i;
          state_d = bfa_pkg::S_DISPATCH;
        end
      end

      bfa_pkg::S_DISPATCH: begin
        if (op_q == bfa_pkg::OP_LOAD) begin
          halted_d        = 1'b0;
          tbl_req.wr_en   = idx_ok;
          tbl_req.wr_addr = idx_q[bfa_pkg::ADDR_W-1:0];
          tbl_req.wr_data = size_q;
          res_status_d    = bfa_pkg::STAT_LOADED;
          res_chosen_d    = idx_q;
          res_remaining_d = idx_ok ? size_q : '0;
          state_d         = bfa_pkg::S_EMIT;
        end else if (halted_q) begin
          res_status_d    = bfa_pkg::STAT_REFUSED;
          res_chosen_d    = '0;
          res_remaining_d = '0;
          state_d         = bfa_pkg::S_EMIT;
        end else begin
          cnt_d       = '0;
          limit_d     = count_sat;
          have_pick_d = 1'b0;
          state_d     = bfa_pkg::S_SCAN;
        end
      end

      bfa_pkg::S_SCAN: begin
        // issue one read a cycle, judge the block read the cycle before
        if (rd_more) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = cnt_q[bfa_pkg::ADDR_W-1:0];
          cnt_d           = cnt_q + bfa_pkg::CNT_W'(1);
        end
        pv_d   = rd_more;
        ptag_d = cnt_q[bfa_pkg::ADDR_W-1:0];
        if (pv_q && take) begin
          have_pick_d = 1'b1;
          pick_d      = ptag_q;
          best_d      = tbl_rdata;
        end
        if (!rd_more && !pv_q) begin
          if (have_pick_q) begin
            state_d = bfa_pkg::S_WRITE;
          end else begin
            halted_d        = 1'b1;
            res_status_d    = bfa_pkg::STAT_NOFIT;
            res_chosen_d    = '0;
            res_remaining_d = '0;
            state_d         = bfa_pkg::S_EMIT;
          end
        end
      end

      bfa_pkg::S_WRITE: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = pick_q;
        tbl_req.wr_data = best_q - size_q;
        res_status_d    = bfa_pkg::STAT_GRANTED;
        res_chosen_d    = bfa_pkg::IDX_W'(pick_q);
        res_remaining_d = best_q - size_q;
        state_d         = bfa_pkg::S_EMIT;
      end

      bfa_pkg::S_EMIT: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_status_d    = res_status_q;
          out_chosen_d    = res_chosen_q;
          out_remaining_d = res_remaining_q;
          state_d         = bfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::S_IDLE;
      pv_q        <= 1'b0;
      have_pick_q <= 1'b0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pv_q        <= pv_d;
      have_pick_q <= have_pick_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= bfa_pkg::POL_FIRST;
      block_count_q <= bfa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfa_pkg::CFG_FIT_POLICY: begin
          fit_policy_q <= cfg_data_i[bfa_pkg::POL_W-1:0];
        end
        bfa_pkg::CFG_BLOCK_COUNT: begin
          block_count_q <= cfg_data_i;
        end
        default: begin
          block_count_q <= block_count_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q            <= op_d;
    idx_q           <= idx_d;
    size_q          <= size_d;
    cnt_q           <= cnt_d;
    limit_q         <= limit_d;
    ptag_q          <= ptag_d;
    pick_q          <= pick_d;
    best_q          <= best_d;
    res_status_q    <= res_status_d;
    res_chosen_q    <= res_chosen_d;
    res_remaining_q <= res_remaining_d;
    out_status_q    <= out_status_d;
    out_chosen_q    <= out_chosen_d;
    out_remaining_q <= out_remaining_d;
  end

  assign in_stall_o     = (state_q != bfa_pkg::S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign chosen_block_o = out_chosen_q;
  assign remaining_o    = out_remaining_q;

  // a grant always follows a scan that found a block
  `BFA_ASSERT(a_write_has_pick, (state_q == bfa_pkg::S_WRITE) |-> have_pick_q)
  // the picked block always covers the request
  `BFA_ASSERT(a_pick_fits, (state_q == bfa_pkg::S_WRITE) |-> (best_q >= size_q))
  // the scan never runs past its limit
  `BFA_ASSERT(a_scan_bound, (state_q == bfa_pkg::S_SCAN) |-> (cnt_q <= limit_q))
  // a refusal is only ever handed over while halted
  `BFA_ASSERT(a_refuse_halted,
    ((state_q == bfa_pkg::S_EMIT) && (res_status_q == bfa_pkg::STAT_REFUSED)) |-> halted_q)
  // a stalled result is never dropped
  `BFA_ASSERT(a_result_kept, (out_valid_q && out_stall_i) |=> out_valid_q)
  // no stale read flagged out of reset
  `BFA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_q && !pv_q))

endmodule

// ===== rtl/core/bfa_table.sv =====
// block free size table: memory with one write and one read port and per-entry valid bits
module bfa_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfa_pkg::tbl_req_t             req_i,
  output logic [bfa_pkg::SIZE_BITS-1:0] rd_data_o
);

  logic [bfa_pkg::SIZE_BITS-1:0]  mem_q [bfa_pkg::NUM_BLOCKS];
  logic [bfa_pkg::NUM_BLOCKS-1:0] valid_q;
  logic [bfa_pkg::SIZE_BITS-1:0]  rdata_q;
  logic                           rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/core/bfa_cmp.sv =====
// shared fit comparator: decides whether a scanned block replaces the current pick
module bfa_cmp (
  input  bfa_pkg::cmp_in_t cmp_i,
  output logic             take_o
);

  logic fits;
  logic better;

  always_comb begin
    fits = (cmp_i.avail >= cmp_i.request);
    // strict compares keep ties on the lower index
    if (cmp_i.policy == bfa_pkg::POL_BEST) begin
      better = (cmp_i.avail < cmp_i.pick_avail);
    end else if (cmp_i.policy == bfa_pkg::POL_WORST) begin
      better = (cmp_i.avail > cmp_i.pick_avail);
    end else begin
      better = 1'b0;
    end
    take_o = fits && (!cmp_i.have_pick || better);
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the block fit allocator: directed script, then random phases
`timescale 1ns / 1ps

module tb;
  import bfa_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int IDLE_LIMIT  = 2000;
  // quiet cycles before a register write and at the very end
  localparam int SETTLE_GAP  = 8;
  localparam int TAIL_GAP    = 80;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int REPORT_MAX  = 10;
  // the spare policy code, which the block treats as first fit
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     chosen;
    logic [SIZE_BITS-1:0] remaining;
  } outcome_t;

  // a script line is either a request or a register write
  typedef enum logic {
    ROW_REQ,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  op;
    logic [IDX_W-1:0]      idx;
    logic [SIZE_BITS-1:0]  size;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    outcome_t              want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  op_i;
  logic [IDX_W-1:0]      block_index_i;
  logic [SIZE_BITS-1:0]  size_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STAT_W-1:0]     status_o;
  logic [IDX_W-1:0]      chosen_block_o;
  logic [SIZE_BITS-1:0]  remaining_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // our own copy of the allocator state and its two registers
  logic [SIZE_BITS-1:0]  free_size [NUM_BLOCKS];
  logic                  halted_now;
  logic [POL_W-1:0]      policy_now;
  logic [CFG_DATA_W-1:0] count_now;

  outcome_t outcomes_due [$];
  outcome_t due;
  row_t     script [$];
  int       mismatches   = 0;
  int       results_seen = 0;
  int       idle_cycles  = 0;
  // set for one whole phase: neither side idles nor stalls
  bit       calm = 1'b0;

  block_fit_allocator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .block_index_i  (block_index_i),
    .size_i         (size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .chosen_block_o (chosen_block_o),
    .remaining_o    (remaining_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // script lines: a plain request, a request with its result spelt out, a register write
  function automatic row_t req_row(logic op, logic [IDX_W-1:0] idx,
                                   logic [SIZE_BITS-1:0] size);
    row_t r;
    r      = '0;
    r.kind = ROW_REQ;
    r.op   = op;
    r.idx  = idx;
    r.size = size;
    return r;
  endfunction

  function automatic row_t known_row(logic op, logic [IDX_W-1:0] idx,
                                     logic [SIZE_BITS-1:0] size, logic [STAT_W-1:0] status,
                                     logic [IDX_W-1:0] chosen,
                                     logic [SIZE_BITS-1:0] remaining);
    row_t r;
    r                = req_row(op, idx, size);
    r.typed          = 1'b1;
    r.want.status    = status;
    r.want.chosen    = chosen;
    r.want.remaining = remaining;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] reg_idx,
                                   logic [CFG_DATA_W-1:0] data);
    row_t r;
    r          = '0;
    r.kind     = ROW_REG;
    r.reg_idx  = reg_idx;
    r.reg_data = data;
    return r;
  endfunction

  // applies one request to the model state and returns the result it should give
  function automatic outcome_t take_request(logic op, logic [IDX_W-1:0] idx,
                                            logic [SIZE_BITS-1:0] size);
    outcome_t res;
    int       limit;
    int       pick;
    res = '0;
    if (op == OP_LOAD) begin
      halted_now = 1'b0;
      res.status = STAT_LOADED;
      res.chosen = idx;
      if (int'(idx) < NUM_BLOCKS) begin
        free_size[idx] = size;
        res.remaining  = size;
      end
    end else if (halted_now) begin
      res.status = STAT_REFUSED;
    end else begin
      limit = (int'(count_now) > NUM_BLOCKS) ? NUM_BLOCKS : int'(count_now);
      pick  = -1;
      // first fit keeps the first hit; best and worst only move on a strict win
      for (int i = 0; i < limit; i++) begin
        if (free_size[i] >= size) begin
          if (pick < 0) begin
            pick = i;
          end else if (policy_now == POL_BEST && free_size[i] < free_size[pick]) begin
            pick = i;
          end else if (policy_now == POL_WORST && free_size[i] > free_size[pick]) begin
            pick = i;
          end
        end
      end
      if (pick < 0) begin
        halted_now = 1'b1;
        res.status = STAT_NOFIT;
      end else begin
        free_size[pick] = free_size[pick] - size;
        res.status      = STAT_GRANTED;
        res.chosen      = IDX_W'(pick);
        res.remaining   = free_size[pick];
      end
    end
    return res;
  endfunction

  // drop both valids, wait for every outstanding result, then let the block go quiet
  task automatic settle(input int gap);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
  endtask

  // valid is left high; the next request or settle lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FIT_POLICY) begin
      policy_now = data[POL_W-1:0];
    end else begin
      count_now = data;
    end
  endtask

  // offers one request, possibly after a random gap, and queues its expected result
  task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [SIZE_BITS-1:0] size, input logic typed,
                              input outcome_t want);
    outcome_t model;
    cfg_valid_i <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    block_index_i <= idx;
    size_i        <= size;
    do @(posedge clk_i); while (in_stall_o);
    // the model always runs so that its state stays in step with the block
    model = take_request(op, idx, size);
    outcomes_due.push_back(typed ? want : model);
  endtask

  // result side stalls at random, except during the calm phase
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 35);
  end

  // every result handed over is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("result %0d with nothing outstanding: status %0d block %0d remaining %0d",
                   results_seen, status_o, chosen_block_o, remaining_o);
        end
      end else begin
        due = outcomes_due.pop_front();
        if (status_o !== due.status || chosen_block_o !== due.chosen ||
            remaining_o !== due.remaining) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result %0d: expected status %0d block %0d remaining %0d",
                     results_seen, due.status, due.chosen, due.remaining);
            $display("result %0d: got      status %0d block %0d remaining %0d",
                     results_seen, status_o, chosen_block_o, remaining_o);
          end
        end
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("block_fit_allocator: mismatch");
    $finish;
  end

  initial begin
    logic [POL_W-1:0]      pol;
    logic [CFG_DATA_W-1:0] cnt;
    logic                  op;
    logic [IDX_W-1:0]      idx;
    logic [SIZE_BITS-1:0]  size;
    int                    span;
    int                    choice;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_LOAD;
    block_index_i = '0;
    size_i        = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FIT_POLICY;
    cfg_data_i    = '0;
    foreach (free_size[i]) free_size[i] = '0;
    halted_now = 1'b0;
    policy_now = POL_FIRST;
    count_now  = BLOCK_COUNT_RST;

    // directed script: empty table after reset, the halt and its release, each policy
    // with a tie, the spare policy code, an empty search, a saturated count, size zero
    script.push_back(known_row(OP_ALLOC, 6'd0, 16'd0, STAT_GRANTED, 6'd0, 16'd0));
    script.push_back(known_row(OP_ALLOC, 6'd0, 16'd1, STAT_NOFIT, 6'd0, 16'd0));
    script.push_back(known_row(OP_ALLOC, 6'd63, 16'hffff, STAT_REFUSED, 6'd0, 16'd0));
    script.push_back(known_row(OP_LOAD, 6'd63, 16'hffff, STAT_LOADED, 6'd63, 16'hffff));
    script.push_back(known_row(OP_LOAD, 6'd0, 16'd100, STAT_LOADED, 6'd0, 16'd100));
    script.push_back(req_row(OP_LOAD, 6'd5, 16'd40));
    script.push_back(req_row(OP_LOAD, 6'd9, 16'd60));
    script.push_back(req_row(OP_ALLOC, 6'd17, 16'd30));
    script.push_back(known_row(OP_ALLOC, 6'd42, 16'hffff, STAT_GRANTED, 6'd63, 16'd0));
    script.push_back(reg_row(CFG_FIT_POLICY, CFG_DATA_W'(POL_BEST)));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd35));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd0));
    script.push_back(reg_row(CFG_FIT_POLICY, CFG_DATA_W'(POL_WORST)));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd10));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd1));
    script.push_back(reg_row(CFG_FIT_POLICY, CFG_DATA_W'(POL_SPARE)));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd50));
    script.push_back(reg_row(CFG_BLOCK_COUNT, 7'd0));
    script.push_back(known_row(OP_ALLOC, 6'd0, 16'd0, STAT_NOFIT, 6'd0, 16'd0));
    script.push_back(known_row(OP_ALLOC, 6'd0, 16'd0, STAT_REFUSED, 6'd0, 16'd0));
    script.push_back(known_row(OP_LOAD, 6'd1, 16'd0, STAT_LOADED, 6'd1, 16'd0));
    script.push_back(reg_row(CFG_BLOCK_COUNT, 7'd127));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd60));
    script.push_back(reg_row(CFG_BLOCK_COUNT, 7'd1));
    script.push_back(reg_row(CFG_FIT_POLICY, CFG_DATA_W'(POL_BEST)));
    script.push_back(req_row(OP_ALLOC, 6'd0, 16'd5));
    script.push_back(known_row(OP_ALLOC, 6'd0, 16'd5, STAT_NOFIT, 6'd0, 16'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_REG) begin
        settle(SETTLE_GAP);
        write_reg(script[r].reg_idx, script[r].reg_data);
      end else begin
        send_request(script[r].op, script[r].idx, script[r].size, script[r].typed,
                     script[r].want);
      end
    end

    // random phases, each under its own policy and search length
    for (int p = 0; p < PHASES; p++) begin
      settle(SETTLE_GAP);
      calm = (p == 6);
      pol  = (p < 4) ? p[POL_W-1:0] : POL_W'($urandom_range(0, 3));
      case (p)
        0, 6: cnt = BLOCK_COUNT_RST;
        1: cnt = 7'd127;
        2: cnt = 7'd1;
        4: cnt = 7'd0;
        default: cnt = CFG_DATA_W'($urandom_range(1, 127));
      endcase
      write_reg(CFG_FIT_POLICY, CFG_DATA_W'(pol));
      write_reg(CFG_BLOCK_COUNT, cnt);
      span = (cnt == 0) ? 1 : ((int'(cnt) > NUM_BLOCKS) ? NUM_BLOCKS : int'(cnt));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // loads mostly land inside the searched range so that allocates can hit
        if ($urandom_range(0, 3) == 0) begin
          idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
        end else begin
          idx = IDX_W'($urandom_range(0, span - 1));
        end
        if ($urandom_range(0, 99) < 35) begin
          op = OP_LOAD;
          if ($urandom_range(0, 3) == 0) begin
            size = SIZE_BITS'($urandom_range(0, 65535));
          end else begin
            size = SIZE_BITS'($urandom_range(0, 2047));
          end
        end else begin
          op     = OP_ALLOC;
          choice = $urandom_range(0, 9);
          if (choice < 5) begin
            size = SIZE_BITS'($urandom_range(0, 255));
          end else if (choice < 8) begin
            // exact fit on a live block, now and then one over it
            size = free_size[$urandom_range(0, span - 1)] +
                   SIZE_BITS'($urandom_range(0, 3) == 0);
          end else begin
            size = SIZE_BITS'($urandom_range(0, 65535));
          end
        end
        send_request(op, idx, size, 1'b0, '0);
      end
    end

    calm = 1'b0;
    settle(TAIL_GAP);
    if (mismatches == 0) begin
      $display("block_fit_allocator: match");
    end else begin
      $display("block_fit_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ===== block_fit_allocator.f =====
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_table.sv
rtl/core/bfa_cmp.sv
rtl/core/block_fit_allocator.sv
verif/tb.sv
